// ===== hdl/dtc_pkg.sv =====
// Shared types and constants of the dispatch type tuple cache.
package dtc_pkg;

    localparam int HANDLE_W   = 32;
    localparam int KEY_FIELDS = 4;
    localparam int FIELD_W    = 32;
    localparam int ARITY_W    = 3;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADKEYS  = 3'd4
    } t_status;

    typedef struct packed {
        logic                 mode;
        logic [ARITY_W-1:0]   arity;
        logic [FIELD_W-1:0]   key_first;
        logic [FIELD_W-1:0]   key_second;
        logic [FIELD_W-1:0]   key_third;
        logic [FIELD_W-1:0]   key_fourth;
        logic                 keys_ok;
        logic [HANDLE_W-1:0]  handle_in;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  handle_out;
    } t_rsp;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_chain_ctl;

endpackage

// ===== hdl/dtc_stream_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface dtc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/dispatch_type_tuple_cache_unit.sv =====
// Dispatch cache keyed by argument type tuples, built as a chain of entry cells.
// Arity-zero accesses, inserts and rejected items: result registered in the cycle after the transaction.
// Table lookups: the query walks the entry chain, one register per cell, and the result is registered at its end.
// One item at a time; the next transaction is taken once the result leaves or is leaving.
// Synchronous active-low reset empties every table and the arity-zero slot at once.
module dispatch_type_tuple_cache_unit
    import dtc_pkg::*;
#(
    parameter int MAX_ARITY   = 4,
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_WIDTH   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtc_stream_if.sink    i_req,
    dtc_stream_if.source  o_rsp
);

    localparam int NT = (MAX_ARITY < KEY_FIELDS) ? MAX_ARITY : KEY_FIELDS;
    localparam int TW = (NT > 1) ? $clog2(NT) : 1;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [CW-1:0]                r_count [NT];
    logic                         r_zero_valid;
    logic [HANDLE_W-1:0]          r_zero_handle;
    logic                         r_out_valid;
    t_rsp                         r_out_data;

    t_req                         w_req;
    logic                         w_ready;
    logic                         w_accept;
    logic [TW-1:0]                w_tbl;
    logic [CW-1:0]                w_cur_count;
    logic [KEY_FIELDS-1:0][FIELD_W-1:0] w_fields;
    logic [NT-1:0][KEY_WIDTH-1:0] w_keys;
    logic                         w_imm_valid;
    t_rsp                         w_imm;
    logic                         w_start;
    logic                         w_wr_en;
    logic                         w_zero_wr;
    logic                         w_end;

    t_chain_ctl                   c_ctl    [MAX_ENTRIES+1];
    logic [TW-1:0]                c_tbl    [MAX_ENTRIES+1];
    logic [CW-1:0]                c_count  [MAX_ENTRIES+1];
    logic [NT-1:0][KEY_WIDTH-1:0] c_keys   [MAX_ENTRIES+1];
    logic [HANDLE_W-1:0]          c_handle [MAX_ENTRIES+1];

    assign w_req    = i_req.data;
    assign w_ready  = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept = i_req.valid && w_ready;
    assign i_req.ready = w_ready;

    assign w_fields = {w_req.key_fourth, w_req.key_third, w_req.key_second, w_req.key_first};

    always_comb begin
        for (int j = 0; j < NT; j++) begin
            w_keys[j] = KEY_WIDTH'(w_fields[j]);
        end
    end

    assign w_tbl       = TW'(w_req.arity - 3'd1);
    assign w_cur_count = r_count[w_tbl];

    always_comb begin
        w_imm_valid       = 1'b0;
        w_imm.status      = ST_MISS;
        w_imm.handle_out  = '0;
        w_start           = 1'b0;
        w_wr_en           = 1'b0;
        w_zero_wr         = 1'b0;
        if (w_accept) begin
            if (w_req.arity == '0) begin
                w_imm_valid = 1'b1;
                if (w_req.mode == MODE_INSERT) begin
                    w_imm.status = ST_INSERTED;
                    w_zero_wr    = 1'b1;
                end else if (r_zero_valid) begin
                    w_imm.status     = ST_HIT;
                    w_imm.handle_out = r_zero_handle;
                end
            end else if (w_req.arity > ARITY_W'(NT)) begin
                w_imm_valid  = 1'b1;
                w_imm.status = (w_req.mode == MODE_INSERT) ? ST_BADKEYS : ST_MISS;
            end else if (w_req.mode == MODE_INSERT) begin
                w_imm_valid = 1'b1;
                if (w_cur_count == CW'(MAX_ENTRIES)) begin
                    w_imm.status = ST_FULL;
                end else if (!w_req.keys_ok) begin
                    w_imm.status = ST_BADKEYS;
                end else begin
                    w_imm.status = ST_INSERTED;
                    w_wr_en      = 1'b1;
                end
            end else if (!w_req.keys_ok) begin
                w_imm_valid = 1'b1;
            end else begin
                w_start = 1'b1;
            end
        end
    end

    assign c_ctl[0].valid = w_start;
    assign c_ctl[0].hit   = 1'b0;
    assign c_tbl[0]       = w_tbl;
    assign c_count[0]     = w_cur_count;
    assign c_keys[0]      = w_keys;
    assign c_handle[0]    = '0;

    for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_cell
        dtc_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .NUM_TABLES  (NT),
            .MAX_ENTRIES (MAX_ENTRIES),
            .INDEX       (e)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_wr_en),
            .i_wr_tbl    (w_tbl),
            .i_wr_idx    (IW'(w_cur_count)),
            .i_wr_keys   (w_keys),
            .i_wr_handle (w_req.handle_in),
            .i_ctl       (c_ctl[e]),
            .i_tbl       (c_tbl[e]),
            .i_count     (c_count[e]),
            .i_keys      (c_keys[e]),
            .i_handle    (c_handle[e]),
            .o_ctl       (c_ctl[e+1]),
            .o_tbl       (c_tbl[e+1]),
            .o_count     (c_count[e+1]),
            .o_keys      (c_keys[e+1]),
            .o_handle    (c_handle[e+1])
        );
    end

    assign w_end = c_ctl[MAX_ENTRIES].valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_end) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_zero_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int t = 0; t < NT; t++) begin
                r_count[t] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_zero_wr) r_zero_valid <= 1'b1;
            if (w_wr_en) r_count[w_tbl] <= w_cur_count + CW'(1);
            if (w_imm_valid || w_end) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_zero_wr) r_zero_handle <= w_req.handle_in;
        if (w_imm_valid) begin
            r_out_data <= w_imm;
        end else if (w_end) begin
            r_out_data.status     <= c_ctl[MAX_ENTRIES].hit ? ST_HIT : ST_MISS;
            r_out_data.handle_out <= c_handle[MAX_ENTRIES];
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

endmodule

// ===== hdl/dtc_cell.sv =====
// One cache entry slot of every arity table, one stage of the lookup chain.
module dtc_cell
    import dtc_pkg::*;
#(
    parameter int KEY_WIDTH   = 32,
    parameter int NUM_TABLES  = 4,
    parameter int MAX_ENTRIES = 16,
    parameter int INDEX       = 0,
    localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [TW-1:0]                         i_wr_tbl,
    input  logic [IW-1:0]                         i_wr_idx,
    input  logic [NUM_TABLES-1:0][KEY_WIDTH-1:0]  i_wr_keys,
    input  logic [HANDLE_W-1:0]                   i_wr_handle,
    input  t_chain_ctl                            i_ctl,
    input  logic [TW-1:0]                         i_tbl,
    input  logic [CW-1:0]                         i_count,
    input  logic [NUM_TABLES-1:0][KEY_WIDTH-1:0]  i_keys,
    input  logic [HANDLE_W-1:0]                   i_handle,
    output t_chain_ctl                            o_ctl,
    output logic [TW-1:0]                         o_tbl,
    output logic [CW-1:0]                         o_count,
    output logic [NUM_TABLES-1:0][KEY_WIDTH-1:0]  o_keys,
    output logic [HANDLE_W-1:0]                   o_handle
);

    logic [NUM_TABLES-1:0][KEY_WIDTH-1:0] r_keys [NUM_TABLES];
    logic [HANDLE_W-1:0]                  r_handle [NUM_TABLES];

    t_chain_ctl                           r_ctl;
    t_chain_ctl                           n_ctl;
    logic [TW-1:0]                        r_tbl;
    logic [CW-1:0]                        r_count;
    logic [NUM_TABLES-1:0][KEY_WIDTH-1:0] r_qkeys;
    logic [HANDLE_W-1:0]                  r_qhandle;
    logic [HANDLE_W-1:0]                  n_qhandle;
    logic                                 w_match;
    logic                                 w_take;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_idx == IW'(INDEX)) begin
            r_keys[i_wr_tbl]   <= i_wr_keys;
            r_handle[i_wr_tbl] <= i_wr_handle;
        end
    end

    always_comb begin
        w_match = 1'b1;
        for (int j = 0; j < NUM_TABLES; j++) begin
            if (TW'(j) <= i_tbl && r_keys[i_tbl][j] != i_keys[j]) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_take = i_ctl.valid && !i_ctl.hit && (CW'(INDEX) < i_count) && w_match;

    always_comb begin
        n_ctl.valid = i_ctl.valid;
        n_ctl.hit   = i_ctl.hit | w_take;
        n_qhandle   = w_take ? r_handle[i_tbl] : i_handle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tbl     <= i_tbl;
        r_count   <= i_count;
        r_qkeys   <= i_keys;
        r_qhandle <= n_qhandle;
    end

    assign o_ctl    = r_ctl;
    assign o_tbl    = r_tbl;
    assign o_count  = r_count;
    assign o_keys   = r_qkeys;
    assign o_handle = r_qhandle;

endmodule
